>>> design/lif_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lif_pkg: shared constants for the LIF neuron integrator
// Mode and register codes, fixed-point constants, divide-by-six constants.
// ----------------------------------------------------------------------------
package lif_pkg;

  // integrator_mode codes; any other code runs the exponential update
  localparam logic [1:0] MODE_EULER = 2'd0;
  localparam logic [1:0] MODE_RK4   = 2'd1;
  localparam logic [1:0] MODE_EXP   = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_MODE      = 3'd0;
  localparam logic [2:0] CFG_LEAK      = 3'd1;
  localparam logic [2:0] CFG_THRESHOLD = 3'd2;
  localparam logic [2:0] CFG_DECAY     = 3'd3;
  localparam logic [2:0] CFG_GAIN      = 3'd4;

  // configuration reset values
  localparam logic [1:0]         MODE_RST      = MODE_EULER;
  localparam logic [15:0]        LEAK_RST      = 16'd4096;
  localparam logic signed [15:0] THRESHOLD_RST = 16'sd256;
  localparam logic [15:0]        DECAY_RST     = 16'd62340;
  localparam logic [15:0]        GAIN_RST      = 16'd3196;

  // time step 0.05 in Q0.16, spike and post-spike potentials in Q.8
  localparam int DT_Q16      = 3277;
  localparam int SPIKE_VALUE = 15360;
  localparam int RESET_VALUE = -256;

  // floor(t / 6) = (t * 43) >> 8 for t below 96
  localparam int DIV6_RECIP = 43;
  localparam int DIV6_SHIFT = 8;

endpackage

>>> design/lif_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lif_if: valid/ready channels of the LIF neuron integrator
// Input current channel and result channel.
// ----------------------------------------------------------------------------
interface lif_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] input_current;

  modport source (output valid, output input_current, input ready);
  modport sink   (input valid, input input_current, output ready);
endinterface

interface lif_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] membrane_potential;
  logic               spike;
  logic               saturated;

  modport source (output valid, output membrane_potential, output spike,
                  output saturated, input ready);
  modport sink   (input valid, input membrane_potential, input spike,
                  input saturated, output ready);
endinterface

>>> design/lif_div6.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lif_div6: iterative signed divide by six with rounding
// Returns floor((operand + 3) / 6), four quotient bits per cycle.
// ----------------------------------------------------------------------------
module lif_div6
  import lif_pkg::*;
#(
  parameter int W  = 40,
  parameter int QW = 37
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [W-1:0]  operand_i,
  output logic                 done_o,
  output logic signed [QW-1:0] quot_o
);

  // biased dividend is nonnegative and below 2^(W+3)
  localparam int DN   = (W + 6) / 4;
  localparam int DW   = 4 * DN;
  localparam int CNTW = $clog2(DN);

  logic signed [W:0] y;
  logic [DW-1:0]     biased;
  logic [DW-1:0]     div_q;
  logic [2:0]        rem_q;
  logic [CNTW-1:0]   cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [6:0]        part;
  logic [11:0]       recip_prod;
  logic [3:0]        qdig;
  logic [6:0]        part_rem;
  logic [DW-1:0]     qdiff;

  assign y      = $signed({operand_i[W-1], operand_i}) + (W+1)'(3);
  assign biased = DW'(y) + (DW'(6) << W);

  assign part       = {rem_q, div_q[DW-1 -: 4]};
  assign recip_prod = 12'(part) * 12'(DIV6_RECIP);
  assign qdig       = recip_prod[DIV6_SHIFT +: 4];
  assign part_rem   = part - 7'({qdig, 2'b00}) - 7'({qdig, 1'b0});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(DN - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - CNTW'(1);
        end
      end
    end
  end

  // dividend shifts out at the top while quotient digits shift in below
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= biased;
      rem_q <= 3'd0;
    end else if (busy_q) begin
      div_q <= {div_q[DW-5:0], qdig};
      rem_q <= part_rem[2:0];
    end
  end

  assign qdiff  = div_q - (DW'(1) << W);
  assign quot_o = $signed(qdiff[QW-1:0]);
  assign done_o = done_q;

endmodule

>>> design/lif_neuron_integrator_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lif_neuron_integrator_step: leaky integrate-and-fire neuron, one step a beat
// Advances the membrane potential by one Euler, RK4 or exponential step.
// ----------------------------------------------------------------------------
// Usage:
//   cur_i carries one input current beat per time step; res_o returns one
//   beat per input with the new potential, the spike flag and the clamp flag.
//   Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i; the user
//   is to write it only while the block is idle, which the block itself
//   leaves unenforced. Writes to unused indexes are dropped. One item is in
//   flight at a time: cur_i.ready is high only when the sequencer is idle.
//   All products outside the divide by six go through one shared multiplier
//   with a registered output. Euler runs one slope round, RK4 four slope
//   rounds plus the four-bit-per-cycle divide by six, the exponential update
//   the decay and gain products, and the step after a spike goes straight to
//   the result. The next input can be taken in the cycle after the result is
//   loaded. The result sits in an output register; a stalled receiver holds
//   it there and the block still accepts and works on the next input, but it
//   waits before loading a new result. Reset clears the potential and the
//   spike history and loads the register defaults.
// ----------------------------------------------------------------------------
module lif_neuron_integrator_step
  import lif_pkg::*;
#(
  parameter int POTENTIAL_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  lif_in_if.sink      cur_i,
  lif_out_if.source   res_o
);

  localparam int P  = POTENTIAL_WIDTH;
  localparam int XW = P + 2;    // intermediate RK points
  localparam int KW = P + 21;   // slopes and the averaged slope
  localparam int SW = KW + 3;   // weighted slope sum
  localparam int PW = KW + 17;  // multiplier product
  localparam int AW = PW + 1;   // advance / exponential accumulator
  localparam int OW = (P > 16) ? P : 16;

  localparam longint POT_MAX_L = (64'sd1 <<< (P - 1)) - 64'sd1;
  localparam longint POT_MIN_L = -POT_MAX_L - 64'sd1;
  localparam longint SPIKE_L   = (64'(SPIKE_VALUE) > POT_MAX_L) ? POT_MAX_L
                                                                 : 64'(SPIKE_VALUE);

  localparam logic signed [AW-1:0] POT_MAX_W = AW'(POT_MAX_L);
  localparam logic signed [AW-1:0] POT_MIN_W = AW'(POT_MIN_L);
  localparam logic signed [P-1:0]  POT_MAX_P = P'(POT_MAX_L);
  localparam logic signed [P-1:0]  POT_MIN_P = P'(POT_MIN_L);
  localparam logic signed [P-1:0]  SPIKE_P   = P'(SPIKE_L);
  localparam logic signed [P-1:0]  RESET_P   = P'(RESET_VALUE);
  localparam logic signed [AW-1:0] RND_15    = AW'(1) << 15;
  localparam logic signed [AW-1:0] RND_27    = AW'(1) << 27;
  localparam logic signed [AW-1:0] RND_28    = AW'(1) << 28;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_AX,
    ST_SLOPE,
    ST_MUL_K,
    ST_ADV,
    ST_DIV,
    ST_EXP_XD,
    ST_EXP_IG,
    ST_EXP_SUM,
    ST_SAT,
    ST_DONE
  } state_e;

  // configuration
  logic [1:0]         mode_q;
  logic [15:0]        leak_q;
  logic signed [15:0] thr_q;
  logic [15:0]        decay_q;
  logic [15:0]        gain_q;

  // sequencer and datapath
  state_e             state_q;
  logic [1:0]         stage_q;
  logic               fin_q;
  logic signed [15:0] cur_q;
  logic signed [P-1:0]  pot_q;
  logic               spiked_q;
  logic signed [XW-1:0] xs_q;
  logic signed [KW-1:0] k_q;
  logic signed [SW-1:0] sum_q;
  logic signed [PW-1:0] prod_q;
  logic signed [AW-1:0] acc_q;
  logic signed [P-1:0]  res_pot_q;
  logic               res_fire_q;
  logic               res_sat_q;

  // output register
  logic               out_valid_q;
  logic signed [15:0] out_pot_q;
  logic               out_spike_q;
  logic               out_sat_q;

  logic signed [KW-1:0] mul_a;
  logic signed [16:0]   mul_b;
  logic signed [PW-1:0] prod_d;
  logic signed [KW-1:0] cur_sh;
  logic signed [KW-1:0] k_slope;
  logic signed [SW-1:0] k_ext;
  logic signed [SW-1:0] sum_d;
  logic signed [AW-1:0] adv_sum;
  logic signed [AW-1:0] adv_res;
  logic signed [AW-1:0] exp_res;
  logic                 sat_hi;
  logic                 sat_lo;
  logic signed [P-1:0]  nv_sat;
  logic                 fire;
  logic signed [OW-1:0] res_ext;
  logic                 in_acc;
  logic                 out_free;
  logic                 div_start;
  logic                 div_done;
  logic signed [KW-1:0] div_quot;

  assign in_acc   = cur_i.valid && cur_i.ready;
  assign out_free = !out_valid_q || res_o.ready;

  // shared multiplier, operands chosen by the sequencer
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_MUL_AX: begin
        mul_a = KW'(xs_q);
        mul_b = $signed({1'b0, leak_q});
      end
      ST_MUL_K: begin
        mul_a = k_q;
        mul_b = 17'(DT_Q16);
      end
      ST_EXP_XD: begin
        mul_a = KW'(pot_q);
        mul_b = $signed({1'b0, decay_q});
      end
      ST_EXP_IG: begin
        mul_a = KW'(cur_q);
        mul_b = $signed({1'b0, gain_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // slope I - A*x in Q.20 and the RK4 weighted sum
  assign cur_sh  = {{(KW-28){cur_q[15]}}, cur_q, 12'b0};
  assign k_slope = cur_sh - $signed(prod_q[KW-1:0]);
  assign k_ext   = SW'(k_slope);
  assign sum_d   = ((stage_q == 2'd0) ? SW'(0) : sum_q)
                 + (((stage_q == 2'd1) || (stage_q == 2'd2)) ? (k_ext <<< 1) : k_ext);

  // x + h*k with round half up; half step for the first two RK4 points
  assign adv_sum = (AW'(pot_q) <<< 28) + AW'(prod_q);
  assign adv_res = (!fin_q && (stage_q != 2'd2)) ? ((adv_sum + RND_28) >>> 29)
                                                 : ((adv_sum + RND_27) >>> 28);
  assign exp_res = (acc_q + AW'(prod_q) + RND_15) >>> 16;

  // clamp, then threshold test on the clamped value
  assign sat_hi = acc_q > POT_MAX_W;
  assign sat_lo = acc_q < POT_MIN_W;
  assign nv_sat = sat_hi ? POT_MAX_P : (sat_lo ? POT_MIN_P : acc_q[P-1:0]);
  assign fire   = AW'(nv_sat) > AW'(thr_q);

  assign div_start = (state_q == ST_SLOPE) && (mode_q == MODE_RK4) && (stage_q == 2'd3);

  lif_div6 #(
    .W  (SW),
    .QW (KW)
  ) u_div6 (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .operand_i (sum_d),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_RST;
      leak_q  <= LEAK_RST;
      thr_q   <= THRESHOLD_RST;
      decay_q <= DECAY_RST;
      gain_q  <= GAIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE:      mode_q  <= cfg_data_i[1:0];
        CFG_LEAK:      leak_q  <= cfg_data_i;
        CFG_THRESHOLD: thr_q   <= $signed(cfg_data_i);
        CFG_DECAY:     decay_q <= cfg_data_i;
        CFG_GAIN:      gain_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      stage_q     <= 2'd0;
      fin_q       <= 1'b0;
      pot_q       <= '0;
      spiked_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // ST_DONE decides the output valid itself
      if (out_valid_q && res_o.ready && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            cur_q   <= cur_i.input_current;
            xs_q    <= XW'(pot_q);
            stage_q <= 2'd0;
            fin_q   <= (mode_q == MODE_EULER);
            if (spiked_q) begin
              // step after a spike ignores its input
              res_pot_q  <= RESET_P;
              res_fire_q <= 1'b0;
              res_sat_q  <= 1'b0;
              state_q    <= ST_DONE;
            end else begin
              case (mode_q)
                MODE_EULER: state_q <= ST_MUL_AX;
                MODE_RK4:   state_q <= ST_MUL_AX;
                default:    state_q <= ST_EXP_XD;
              endcase
            end
          end
        end
        ST_MUL_AX: state_q <= ST_SLOPE;
        ST_SLOPE: begin
          k_q   <= k_slope;
          sum_q <= sum_d;
          if (div_start) begin
            state_q <= ST_DIV;
          end else begin
            state_q <= ST_MUL_K;
          end
        end
        ST_MUL_K: state_q <= ST_ADV;
        ST_ADV: begin
          if (fin_q) begin
            acc_q   <= adv_res;
            state_q <= ST_SAT;
          end else begin
            xs_q    <= adv_res[XW-1:0];
            stage_q <= stage_q + 2'd1;
            state_q <= ST_MUL_AX;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            k_q     <= div_quot;
            fin_q   <= 1'b1;
            state_q <= ST_MUL_K;
          end
        end
        ST_EXP_XD: state_q <= ST_EXP_IG;
        ST_EXP_IG: begin
          acc_q   <= AW'(prod_q);
          state_q <= ST_EXP_SUM;
        end
        ST_EXP_SUM: begin
          acc_q   <= exp_res;
          state_q <= ST_SAT;
        end
        ST_SAT: begin
          res_pot_q  <= fire ? SPIKE_P : nv_sat;
          res_fire_q <= fire;
          res_sat_q  <= sat_hi || sat_lo;
          state_q    <= ST_DONE;
        end
        ST_DONE: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_pot_q   <= res_ext[15:0];
            out_spike_q <= res_fire_q;
            out_sat_q   <= res_sat_q;
            pot_q       <= res_pot_q;
            spiked_q    <= res_fire_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign res_ext = OW'(res_pot_q);

  assign cur_i.ready              = (state_q == ST_IDLE);
  assign res_o.valid              = out_valid_q;
  assign res_o.membrane_potential = out_pot_q;
  assign res_o.spike              = out_spike_q;
  assign res_o.saturated          = out_sat_q;

endmodule

>>> design/lif_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lif_chk: port-level checks for the LIF neuron integrator
// Watches the channels of the top level; attached by bind.
// ----------------------------------------------------------------------------
module lif_chk #(
  parameter int POTENTIAL_WIDTH = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] out_pot_i,
  input logic        out_spike_i,
  input logic        out_sat_i
);

  localparam longint POT_MAX_L = (64'sd1 <<< (POTENTIAL_WIDTH - 1)) - 64'sd1;
  localparam longint POT_MIN_L = -POT_MAX_L - 64'sd1;
  localparam longint SPIKE_L   = (64'sd15360 > POT_MAX_L) ? POT_MAX_L : 64'sd15360;
  localparam logic [15:0] SPIKE16  = 16'(SPIKE_L);
  localparam logic [15:0] SAT_HI16 = 16'(POT_MAX_L);
  localparam logic [15:0] SAT_LO16 = 16'(POT_MIN_L);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_pot_i) && $stable(out_spike_i) && $stable(out_sat_i))
    else $error("result beat changed while stalled");

  // one item in flight: no input beat right after an accepted one
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted while a step is running");

  // a firing step reports the spike value
  a_spike_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_spike_i |-> out_pot_i == SPIKE16)
    else $error("spike beat without the spike value");

  // a clamped potential that does not fire sits at a range limit
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_sat_i && !out_spike_i |->
      (out_pot_i == SAT_HI16) || (out_pot_i == SAT_LO16))
    else $error("saturated beat away from the range limits");

endmodule

bind lif_neuron_integrator_step lif_chk #(
  .POTENTIAL_WIDTH (POTENTIAL_WIDTH)
) u_lif_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (cur_i.valid),
  .in_ready_i  (cur_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_pot_i   (res_o.membrane_potential),
  .out_spike_i (res_o.spike),
  .out_sat_i   (res_o.saturated)
);

>>> test/lif_neuron_integrator_step_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lif_neuron_integrator_step_test: self-checking bench for the LIF integrator
// Streams input current beats through all integrator modes and varied register
// settings under random back-pressure. A bit-exact fixed-point predictor
// computes each step, and every result beat is checked in order.
// ----------------------------------------------------------------------------
module lif_neuron_integrator_step_test;
  import lif_pkg::*;

  localparam int     PW            = 16;
  localparam longint POT_HI        = (longint'(1) <<< (PW - 1)) - 1;
  localparam longint POT_LO        = -POT_HI - 1;
  localparam int     SETTLE_CYCLES = 40;
  localparam int     QUIET_LIMIT   = 4000;
  localparam int     HOLD_CYCLES   = 400;
  localparam int     RANDOM_PHASES = 14;
  localparam int     PHASE_ITEMS   = 73;
  // unused mode code, runs as the exponential update
  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic signed [15:0] potential;
    logic               spike;
    logic               saturated;
  } step_result_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               cfg_we    = 1'b0;
  logic [2:0]         cfg_idx   = CFG_MODE;
  logic [15:0]        cfg_data  = '0;
  logic               cur_valid = 1'b0;
  logic signed [15:0] cur_data  = '0;
  logic               res_ready = 1'b0;

  lif_in_if  cur_if ();
  lif_out_if res_if ();

  assign cur_if.valid         = cur_valid;
  assign cur_if.input_current = cur_data;
  assign res_if.ready         = res_ready;

  lif_neuron_integrator_step #(
    .POTENTIAL_WIDTH(PW)
  ) DUT (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .cur_i     (cur_if),
    .res_o     (res_if)
  );

  always #6 clk = ~clk;

  // predictor state and register copy
  logic [1:0]         mode_reg      = MODE_RST;
  logic [15:0]        leak_reg      = LEAK_RST;
  logic signed [15:0] threshold_reg = THRESHOLD_RST;
  logic [15:0]        decay_reg     = DECAY_RST;
  logic [15:0]        gain_reg      = GAIN_RST;
  longint             potential_now = 0;
  bit                 fired_last    = 1'b0;

  logic signed [15:0] current_backlog[$];
  step_result_t       awaited_steps[$];

  int sender_idle_pct   = 11;
  int receiver_idle_pct = 52;
  bit cur_taken         = 1'b0;
  bit hold_request      = 1'b0;
  int mismatch_count    = 0;

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic longint round_half_up(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  // dv/dt = I - A*x in Q.20
  function automatic longint derivative(longint x, longint cur, longint a);
    return cur * 4096 - a * x;
  endfunction

  // x + h*k rounded to Q.8, h is DT or DT/2
  function automatic longint euler_advance(longint x, longint k, bit half);
    return round_half_up(x * (longint'(1) <<< 28) + k * longint'(DT_Q16), half ? 29 : 28);
  endfunction

  function automatic longint floor_div6(longint v);
    longint t, q;
    t = v + 3;
    q = t / 6;
    if (t < 0 && (t % 6) != 0) q = q - 1;
    return q;
  endfunction

  function automatic void integrate_step(logic signed [15:0] cur_raw);
    longint       cur, a, x, nv, k1, k2, k3, k4, d, g;
    step_result_t r;
    cur         = cur_raw;
    a           = leak_reg;
    x           = potential_now;
    r.spike     = 1'b0;
    r.saturated = 1'b0;
    if (fired_last) begin
      // step after a spike drops its input
      fired_last    = 1'b0;
      potential_now = RESET_VALUE;
      nv            = RESET_VALUE;
    end else begin
      case (mode_reg)
        MODE_EULER: nv = euler_advance(x, derivative(x, cur, a), 1'b0);
        MODE_RK4: begin
          k1 = derivative(x, cur, a);
          k2 = derivative(euler_advance(x, k1, 1'b1), cur, a);
          k3 = derivative(euler_advance(x, k2, 1'b1), cur, a);
          k4 = derivative(euler_advance(x, k3, 1'b0), cur, a);
          nv = euler_advance(x, floor_div6(k1 + 2 * k2 + 2 * k3 + k4), 1'b0);
        end
        default: begin
          d  = decay_reg;
          g  = gain_reg;
          nv = round_half_up(x * d + cur * g, 16);
        end
      endcase
      if (nv > POT_HI) begin
        nv          = POT_HI;
        r.saturated = 1'b1;
      end
      if (nv < POT_LO) begin
        nv          = POT_LO;
        r.saturated = 1'b1;
      end
      if (nv > longint'(threshold_reg)) begin
        r.spike    = 1'b1;
        nv         = (SPIKE_VALUE > POT_HI) ? POT_HI : SPIKE_VALUE;
        fired_last = 1'b1;
      end
      potential_now = nv;
    end
    r.potential = nv[15:0];
    awaited_steps.push_back(r);
  endfunction

  // input side: predict every accepted beat
  always @(posedge clk) begin
    if (rst_n && cur_valid && cur_if.ready) begin
      integrate_step(cur_data);
      cur_taken = 1'b1;
    end
  end

  always @(negedge clk) begin : current_driver
    bit taken;
    taken     = cur_taken;
    cur_taken = 1'b0;
    if (taken) void'(current_backlog.pop_front());
    // hold an offered beat until the block takes it
    if (!cur_valid || taken) begin
      if (rst_n && current_backlog.size() != 0 &&
          $urandom_range(0, 99) >= sender_idle_pct) begin
        cur_valid <= 1'b1;
        cur_data  <= current_backlog[0];
      end else begin
        cur_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : result_receiver
    int hold_left;
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_ready <= 1'b0;
    end else begin
      res_ready <= rst_n && ($urandom_range(0, 99) >= receiver_idle_pct);
    end
  end

  always @(posedge clk) begin : result_check
    step_result_t want;
    if (rst_n && res_if.valid && res_ready) begin
      if (awaited_steps.size() == 0) begin
        report_mismatch("result beat with nothing awaited", res_if.membrane_potential, 0);
      end else begin
        want = awaited_steps.pop_front();
        if (res_if.membrane_potential !== want.potential)
          report_mismatch("membrane_potential", res_if.membrane_potential, want.potential);
        if (res_if.spike !== want.spike)
          report_mismatch("spike", res_if.spike, want.spike);
        if (res_if.saturated !== want.saturated)
          report_mismatch("saturated", res_if.saturated, want.saturated);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((cur_valid && cur_if.ready) || (res_if.valid && res_ready)) quiet = 0;
      else quiet++;
    end
    $display("status: fail");
    $finish;
  end

  task automatic write_register(logic [2:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      CFG_MODE:      mode_reg      = data[1:0];
      CFG_LEAK:      leak_reg      = data;
      CFG_THRESHOLD: threshold_reg = data;
      CFG_DECAY:     decay_reg     = data;
      CFG_GAIN:      gain_reg      = data;
      default: ;
    endcase
  endtask

  task automatic set_registers(logic [1:0] mode, logic [15:0] leak, logic [15:0] thr,
                               logic [15:0] decay, logic [15:0] gain);
    write_register(CFG_MODE, {14'b0, mode});
    write_register(CFG_LEAK, leak);
    write_register(CFG_THRESHOLD, thr);
    write_register(CFG_DECAY, decay);
    write_register(CFG_GAIN, gain);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until every beat is taken and every result is back, then settle
  task automatic drain();
    while (current_backlog.size() != 0 || awaited_steps.size() != 0 || cur_valid)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_register(logic [15:0] nominal);
    case ($urandom_range(0, 4))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return nominal;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    logic [1:0]         phase_modes[4];
    logic [15:0]        thr;
    logic signed [15:0] level;
    logic signed [15:0] beat;
    phase_modes = '{MODE_EULER, MODE_RK4, MODE_EXP, MODE_SPARE};
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset defaults: a spike, the ignored step after it, small steps
    current_backlog = '{16'sd0, 16'sh7FFF, 16'sd12345, 16'sh8000, 16'sh8000,
                        16'sd1, -16'sd1};
    drain();
    // unit decay and gain: clamp at both ends, threshold never reached
    set_registers(MODE_EXP, LEAK_RST, 16'h7FFF, 16'hFFFF, 16'hFFFF);
    current_backlog = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000,
                        16'sh8000};
    drain();
    set_registers(MODE_RK4, 16'hFFFF, 16'h0000, DECAY_RST, GAIN_RST);
    current_backlog = '{16'sh7FFF, 16'sd0, 16'sh8000, 16'sd100, 16'sd0};
    drain();
    set_registers(MODE_SPARE, 16'h0000, 16'h8000, 16'h0000, 16'hFFFF);
    current_backlog = '{16'sd1000, 16'sd5, 16'sh8000};
    drain();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase < 5) begin
        sender_idle_pct   = 11;
        receiver_idle_pct = 52;
      end else if (phase < 10) begin
        sender_idle_pct   = 52;
        receiver_idle_pct = 11;
      end else begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
      end
      case ($urandom_range(0, 5))
        0:       thr = 16'h8000;
        1:       thr = 16'h7FFF;
        default: thr = 16'($urandom_range(0, 3072) - 1024);
      endcase
      set_registers(phase_modes[phase % 4], pick_register(LEAK_RST), thr,
                    pick_register(DECAY_RST), pick_register(GAIN_RST));
      level = '0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // steady drive levels with jitter, plus some raw and extreme beats
        if (i % 12 == 0) level = 16'($urandom_range(0, 16384) - 8192);
        case ($urandom_range(0, 19))
          0:       beat = 16'sh7FFF;
          1:       beat = 16'sh8000;
          2, 3:    beat = 16'($urandom);
          default: beat = level + 16'($urandom_range(0, 512) - 256);
        endcase
        current_backlog.push_back(beat);
      end
      // long receiver stall while the sender keeps offering
      if (phase == 3) hold_request = 1'b1;
      drain();
    end

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
